FILE: src/ptts_pkg.sv
// package for the periodic task tick scheduler
// holds sizes, command codes, the scan token and the cell control bundle
// no dependencies
package ptts_pkg;

  localparam int TASKS      = 8;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int SCAN_W     = $clog2(TASKS + 1);

  localparam logic [31:0] CNT_MAX32 = 32'((64'd1 << COUNT_BITS) - 64'd1);

  // command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  // best candidate so far, passed from cell to cell
  typedef struct packed {
    logic             found;
    logic [31:0]      key;
    logic [IDX_W-1:0] idx;
  } token_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             load;
    logic [2:0]       load_idx;
    logic [15:0]      exec_time;
    logic [15:0]      period;
    logic             restart;
    logic             arm;
    logic             grant;
    logic [IDX_W-1:0] grant_idx;
    logic             edf;
    logic [31:0]      now;
  } cell_ctl_t;

  // execution time clipped to the remaining counter range
  function automatic logic [COUNT_BITS-1:0] sat_count(input logic [15:0] ex);
    logic [31:0] wide;
    wide = {16'b0, ex};
    if (wide > CNT_MAX32) begin
      return COUNT_BITS'(CNT_MAX32);
    end
    return COUNT_BITS'(wide);
  endfunction

endpackage

FILE: src/periodic_task_tick_scheduler_top.sv
// top level of the periodic task tick scheduler: apb registers, sequencer, cell chain
// depends on ptts_pkg and ptts_cell
//
//  channel   handshake              payload
//  input     start & !busy          in_command, in_task_index, in_exec_time, in_period
//  result    out_strobe, one cycle  out_running_task, out_idle, out_tick_time
//  config    psel&penable&pwrite    paddr[2] selects policy_mode or task_count
//
// a load or restart transaction is taken while idle and busy stays low
// after a tick is taken busy stays high through ST_ARM, which re-arms all cells, ST_SCAN,
// in which the best candidate ripples through the cell chain, and ST_GRANT, which grants it
// the result strobe follows in the cycle after the grant, when start is taken again
// rst_n is synchronous; run state and time clear, stored entries are kept as is
// the receiver cannot stall, so the result is shown for exactly one cycle
module periodic_task_tick_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_task_index,
  input  logic [15:0] in_exec_time,
  input  logic [15:0] in_period,
  output logic        out_strobe,
  output logic [2:0]  out_running_task,
  output logic        out_idle,
  output logic [31:0] out_tick_time,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARM,
    ST_SCAN,
    ST_GRANT
  } state_t;

  state_t            state_r;
  logic [SCAN_W-1:0] scan_cnt_r;
  logic              policy_r;
  logic [3:0]        task_count_r;
  logic [31:0]       now_r;
  logic              strobe_r;
  logic [2:0]        run_task_r;
  logic              idle_r;
  logic [31:0]       tick_time_r;
  logic              accept;
  logic              cfg_wr;
  cmd_t              cmd;
  cell_ctl_t         ctl;
  token_t            tok [TASKS];
  token_t            best;

  assign cmd    = cmd_t'(in_command);
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign best   = tok[TASKS-1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= 1'b0;
      task_count_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_POLICY: policy_r     <= pwdata[0];
        REG_COUNT:  task_count_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POLICY: prdata = {31'b0, policy_r};
      REG_COUNT:  prdata = {28'b0, task_count_r};
      default:    prdata = '0;
    endcase
  end

  // control broadcast to the cells
  always_comb begin
    ctl.load      = accept && (cmd == CMD_LOAD);
    ctl.load_idx  = in_task_index;
    ctl.exec_time = in_exec_time;
    ctl.period    = in_period;
    ctl.restart   = accept && (cmd == CMD_RESTART);
    ctl.arm       = (state_r == ST_ARM);
    ctl.grant     = (state_r == ST_GRANT) && best.found;
    ctl.grant_idx = best.idx;
    ctl.edf       = policy_r;
    ctl.now       = now_r;
  end

  // sequencer, time counter and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_cnt_r <= '0;
      now_r      <= '0;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (ctl.restart) begin
            now_r <= '0;
          end else if (accept && (cmd == CMD_TICK)) begin
            state_r <= ST_ARM;
          end
        end
        ST_ARM: begin
          scan_cnt_r <= '0;
          state_r    <= ST_SCAN;
        end
        ST_SCAN: begin
          scan_cnt_r <= scan_cnt_r + SCAN_W'(1);
          if (scan_cnt_r == SCAN_W'(TASKS - 1)) begin
            state_r <= ST_GRANT;
          end
        end
        ST_GRANT: begin
          strobe_r    <= 1'b1;
          run_task_r  <= best.found ? 3'(32'(best.idx)) : 3'd0;
          idle_r      <= !best.found;
          tick_time_r <= now_r;
          now_r       <= now_r + 32'd1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_strobe       = strobe_r;
  assign out_running_task = run_task_r;
  assign out_idle         = idle_r;
  assign out_tick_time    = tick_time_r;

  // chain of task cells, lowest index first so ties keep the lower index
  for (genvar k = 0; k < TASKS; k++) begin : g_cell
    token_t tin;
    logic   en;
    if (k == 0) begin : g_head
      assign tin = '0;
    end else begin : g_link
      assign tin = tok[k-1];
    end
    assign en = ({28'b0, task_count_r} > 32'(k));
    ptts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cell_id   (IDX_W'(k)),
      .en        (en),
      .tok_in    (tin),
      .tok_out_r (tok[k])
    );
  end

endmodule

FILE: src/ptts_cell.sv
// one task entry of the scheduler chain: stored entry, run state, compare stage
// depends on ptts_pkg
module ptts_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ptts_pkg::cell_ctl_t       ctl,
  input  logic [ptts_pkg::IDX_W-1:0] cell_id,
  input  logic                      en,
  input  ptts_pkg::token_t          tok_in,
  output ptts_pkg::token_t          tok_out_r
);
  import ptts_pkg::*;

  logic [15:0]           exec_r;
  logic [15:0]           period_r;
  logic [COUNT_BITS-1:0] remain_r, remain_nxt;
  logic [31:0]           release_r, release_nxt;
  logic [31:0]           deadline_r, deadline_nxt;
  token_t                tok_nxt;
  logic [31:0]           key;
  logic                  pending;
  logic                  load_hit;

  assign load_hit = ctl.load && (32'(ctl.load_idx) == 32'(cell_id));

  // entry store, written by load transactions only
  always_ff @(posedge clk) begin
    if (load_hit) begin
      exec_r   <= ctl.exec_time;
      period_r <= ctl.period;
    end
  end

  // run state: restart, re-arm at release, decrement on grant
  always_comb begin
    remain_nxt   = remain_r;
    release_nxt  = release_r;
    deadline_nxt = deadline_r;
    if (ctl.restart) begin
      remain_nxt   = '0;
      release_nxt  = '0;
      deadline_nxt = '0;
    end else if (ctl.arm && en && (release_r == ctl.now)) begin
      remain_nxt   = sat_count(exec_r);
      deadline_nxt = ctl.now + {16'b0, period_r};
      release_nxt  = release_r + {16'b0, period_r};
    end else if (ctl.grant && (ctl.grant_idx == cell_id)) begin
      remain_nxt = remain_r - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r   <= '0;
      release_r  <= '0;
      deadline_r <= '0;
    end else begin
      remain_r   <= remain_nxt;
      release_r  <= release_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  // compare stage: keep the incoming token unless this entry beats it
  assign pending = en && (remain_r != '0);
  assign key     = ctl.edf ? ((deadline_r - ctl.now) ^ 32'h8000_0000) : {16'b0, period_r};

  always_comb begin
    tok_nxt = tok_in;
    if (pending && (!tok_in.found || (key < tok_in.key))) begin
      tok_nxt.found = 1'b1;
      tok_nxt.key   = key;
      tok_nxt.idx   = cell_id;
    end
  end

  always_ff @(posedge clk) begin
    tok_out_r <= tok_nxt;
  end

endmodule

FILE: dv/tick_grant_checker.sv
`timescale 1ns / 100ps
// checker for the periodic task tick scheduler: watches the input, result and apb channels,
// predicts each tick grant and compares it field by field against the result strobe
// depends on ptts_pkg
module tick_grant_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_task_index,
  input  logic [15:0] in_exec_time,
  input  logic [15:0] in_period,
  input  logic        out_strobe,
  input  logic [2:0]  out_running_task,
  input  logic        out_idle,
  input  logic [31:0] out_tick_time,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  import ptts_pkg::*;

  typedef struct packed {
    logic [2:0]  task_id;
    logic        idle;
    logic [31:0] stamp;
  } tick_grant_t;

  // predicted scheduler state
  logic [15:0] exec_mem   [TASKS];
  logic [15:0] period_mem [TASKS];
  logic [15:0] work_left  [TASKS];
  logic [31:0] release_at [TASKS];
  logic [31:0] deadline_at[TASKS];
  logic [31:0] sched_time;
  logic        edf_mode;
  logic [3:0]  active_tasks;

  tick_grant_t grants_due[$];
  int          errors = 0;

  // clear counts, releases, deadlines and time; stored entries stay
  task automatic clear_run();
    for (int i = 0; i < TASKS; i++) begin
      work_left[i]   = '0;
      release_at[i]  = '0;
      deadline_at[i] = '0;
    end
    sched_time = '0;
  endtask

  // re-arm released tasks, pick the winner, charge it one tick
  task automatic schedule_tick(output tick_grant_t grant);
    int         used;
    int         key;
    int         best_key;
    logic       have;
    logic [2:0] pick;
    used     = (active_tasks > TASKS) ? TASKS : int'(active_tasks);
    have     = 1'b0;
    best_key = 0;
    pick     = '0;
    for (int i = 0; i < used; i++) begin
      if (release_at[i] == sched_time) begin
        work_left[i]   = exec_mem[i];
        deadline_at[i] = sched_time + period_mem[i];
        release_at[i]  = release_at[i] + period_mem[i];
      end
    end
    // edf keys are signed slack so a wrapped deadline still orders right
    for (int i = 0; i < used; i++) begin
      if (work_left[i] != 0) begin
        key = edf_mode ? $signed(deadline_at[i] - sched_time) : int'(period_mem[i]);
        if (!have || key < best_key) begin
          have     = 1'b1;
          best_key = key;
          pick     = 3'(i);
        end
      end
    end
    if (have) begin
      work_left[pick] = work_left[pick] - 16'd1;
    end
    grant.task_id = have ? pick : 3'd0;
    grant.idle    = !have;
    grant.stamp   = sched_time;
    sched_time    = sched_time + 32'd1;
  endtask

  always @(posedge clk) begin
    tick_grant_t want;
    tick_grant_t got;
    if (!rst_n) begin
      edf_mode     = 1'b0;
      active_tasks = '0;
      clear_run();
      grants_due.delete();
    end else begin
      // compare a result transaction with the oldest prediction
      if (out_strobe) begin
        got = '{out_running_task, out_idle, out_tick_time};
        if (grants_due.size() == 0) begin
          $display("%0t: unexpected result: task %0d idle %0b time %0d",
                   $time, got.task_id, got.idle, got.stamp);
          errors++;
        end else begin
          want = grants_due.pop_front();
          if (got.task_id !== want.task_id) begin
            $display("%0t: running_task expected %0d actual %0d",
                     $time, want.task_id, got.task_id);
            errors++;
          end
          if (got.idle !== want.idle) begin
            $display("%0t: idle expected %0b actual %0b", $time, want.idle, got.idle);
            errors++;
          end
          if (got.stamp !== want.stamp) begin
            $display("%0t: tick_time expected %0d actual %0d", $time, want.stamp, got.stamp);
            errors++;
          end
        end
      end

      // register write transaction
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_COUNT) begin
          active_tasks = pwdata[3:0];
        end else begin
          edf_mode = pwdata[0];
        end
      end

      // input transaction
      if (start && !busy) begin
        case (cmd_t'(in_command))
          CMD_TICK: begin
            schedule_tick(want);
            grants_due.push_back(want);
          end
          CMD_LOAD: begin
            exec_mem[in_task_index]   = in_exec_time;
            period_mem[in_task_index] = in_period;
          end
          CMD_RESTART: begin
            clear_run();
          end
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending    <= grants_due.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// top of the periodic task tick scheduler testbench: clock, reset, stimulus and verdict
// depends on ptts_pkg, tick_grant_checker and periodic_task_tick_scheduler_top
module testbench;
  import ptts_pkg::*;

  localparam int ITEM_GOAL   = 1300;
  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_NONE;
  logic [2:0]  in_task_index = '0;
  logic [15:0] in_exec_time = '0;
  logic [15:0] in_period = '0;
  logic        out_strobe;
  logic [2:0]  out_running_task;
  logic        out_idle;
  logic [31:0] out_tick_time;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int items_sent = 0;
  int stall_cycles = 0;

  periodic_task_tick_scheduler_top uut (.*);

  tick_grant_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_command, .in_task_index, .in_exec_time, .in_period,
    .out_strobe, .out_running_task, .out_idle, .out_tick_time,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // present one transaction and hold it until taken
  task automatic send_item(input cmd_t cmd, input logic [2:0] idx,
                           input logic [15:0] ex, input logic [15:0] per);
    int gap;
    // no gaps in the middle stretch of the run
    if ((items_sent < 400 || items_sent >= 700) && $urandom_range(0, 99) < 11) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_task_index <= idx;
    in_exec_time  <= ex;
    in_period     <= per;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // load an entry, mostly short periods so that tasks compete
  task automatic send_random_load();
    logic [15:0] ex;
    logic [15:0] per;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      ex  = 16'($urandom);
      per = 16'($urandom);
    end else if (pick == 1) begin
      ex  = 16'($urandom_range(0, 4));
      per = '0;
    end else begin
      per = 16'($urandom_range(1, 12));
      ex  = 16'($urandom_range(0, per));
    end
    send_item(CMD_LOAD, 3'($urandom), ex, per);
  endtask

  // apb write: setup, access, then idle with psel low
  task automatic write_reg(input logic which, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // drain outstanding ticks, then wait with start low
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // watchdog on cycles without any handshake
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_strobe || (psel && penable && pwrite && pready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int runs;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no entries in use after reset: idle tick, then the unused command
    send_item(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_item(CMD_NONE, 3'd7, 16'hffff, 16'hffff);
    // every entry loaded: extremes, zero period, equal periods on 1 and 6
    send_item(CMD_LOAD, 3'd0, 16'd2, 16'd5);
    send_item(CMD_LOAD, 3'd1, 16'd1, 16'd3);
    send_item(CMD_LOAD, 3'd2, 16'd0, 16'd4);
    send_item(CMD_LOAD, 3'd3, 16'hffff, 16'hffff);
    send_item(CMD_LOAD, 3'd4, 16'd1, 16'd0);
    send_item(CMD_LOAD, 3'd5, 16'd3, 16'd7);
    send_item(CMD_LOAD, 3'd6, 16'd2, 16'd3);
    send_item(CMD_LOAD, 3'd7, 16'd1, 16'd1);
    send_item(CMD_RESTART, 3'd0, 16'd0, 16'd0);

    // rate monotonic over all eight entries
    settle();
    write_reg(REG_POLICY, 32'd0);
    write_reg(REG_COUNT, 32'd8);
    repeat (6) send_item(CMD_TICK, 3'd0, 16'd0, 16'd0);

    // edf with an oversized task count
    settle();
    write_reg(REG_POLICY, 32'd1);
    write_reg(REG_COUNT, 32'd15);
    send_item(CMD_RESTART, 3'd0, 16'd0, 16'd0);
    repeat (6) send_item(CMD_TICK, 3'd0, 16'd0, 16'd0);

    // random phases: new settings, some reloads, usually a restart, then a run of mostly ticks
    while (items_sent < ITEM_GOAL) begin
      settle();
      write_reg(REG_POLICY, $urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick == 0)
        write_reg(REG_COUNT, 32'd0);
      else if (pick == 1)
        write_reg(REG_COUNT, 32'd8);
      else if (pick == 2)
        write_reg(REG_COUNT, $urandom_range(9, 15));
      else
        write_reg(REG_COUNT, $urandom_range(1, 8));

      repeat ($urandom_range(0, 4)) send_random_load();
      if ($urandom_range(0, 9) != 0)
        send_item(CMD_RESTART, 3'($urandom), 16'($urandom), 16'($urandom));

      runs = $urandom_range(10, 60);
      repeat (runs) begin
        pick = $urandom_range(0, 99);
        if (pick < 88)
          send_item(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
        else if (pick < 93)
          send_random_load();
        else if (pick < 96)
          send_item(CMD_NONE, 3'($urandom), 16'($urandom), 16'($urandom));
        else if (pick < 98)
          send_item(CMD_RESTART, 3'($urandom), 16'($urandom), 16'($urandom));
        else
          send_item(cmd_t'($urandom_range(0, 3)), 3'($urandom), 16'($urandom),
                    16'($urandom));
      end
    end

    settle();
    if (pending != 0)
      $display("%0t: %0d tick results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
